// ===== rtl/vmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// vmpc_pkg
// Shared types, widths and arithmetic helpers for the min-plus column block.
// ----------------------------------------------------------------------------
package vmpc_pkg;

  localparam int COST_W     = 32;
  localparam int EMIS_W     = 16;
  localparam int BP_W       = 9;
  localparam int IDX_OUT_W  = 8;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [BP_W-1:0]   BP_NONE  = 9'd256;

  // One entry of the previous-column store.
  typedef struct packed {
    logic              enabled;
    logic [COST_W-1:0] cost;
  } prior_entry_t;

  // Add and clamp at the all-ones cost.
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

// ===== rtl/vmpc_prior_ram.sv =====
// ----------------------------------------------------------------------------
// vmpc_prior_ram
// Simple dual-port store for the previous column, registered read.
// ----------------------------------------------------------------------------
module vmpc_prior_ram
  import vmpc_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  prior_entry_t             wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output prior_entry_t             rd_data
);

  prior_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Old data on a same-address collision; the caller forwards around it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/viterbi_min_plus_column.sv =====
// ----------------------------------------------------------------------------
// viterbi_min_plus_column
// Min-plus Viterbi column update, one path cell per word.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the cells of a column on the s_ channel in path order, index 0
//   first, and mark the last cell of each column with s_tlast. Each word
//   gives one result word on the m_ channel, in the same order; m_tlast
//   marks the result of the column's last cell.
//   An accepted word is registered into the compute stage and, when that
//   stage advances, into the output stage. Throughput: one word per cycle
//   while the output is not stalled, set by the single read-modify-write
//   of the previous-column memory (one registered read at accept, one
//   write when the cell leaves the compute stage). A read of the entry
//   written in the same cycle is served from a forwarding register.
//   Reset: clears the pipeline, the cell counter and the running and
//   previous minima. The previous-column memory is not cleared; run a first
//   column (first_column = 1) before relying on previous costs.
//   Stall: when m_tready is low the output word holds, the compute stage
//   fills, and s_tready drops until the output word is taken.
// ----------------------------------------------------------------------------
module viterbi_min_plus_column
  import vmpc_pkg::*;
#(
  parameter int MAX_PATHS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // emission_cost[15:0], switch_cost[47:16], stay_cost[79:48]
  input  logic [1:0]  s_tuser,   // first_column[0], cell_enabled[1]
  input  logic        s_tlast,   // last_in_column
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // cell_cost[31:0], back_pointer[40:32],
                                 // column_best_cost[72:41], column_best_index[80:73],
                                 // zero fill[87:81]
  output logic        m_tlast    // column_done
);

  localparam int IW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int NW = $clog2(MAX_PATHS + 1);
  localparam logic [NW-1:0] NONE_ID  = NW'(MAX_PATHS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PATHS - 1);

  // Handshake and pipeline control
  logic accept;
  logic s1_valid;
  logic s1_adv;
  logic out_valid;

  // Compute-stage word
  logic              s1_first;
  logic              s1_en;
  logic [EMIS_W-1:0] s1_emis;
  logic [COST_W-1:0] s1_sw;
  logic [COST_W-1:0] s1_stay;
  logic              s1_last;
  logic [IW-1:0]     s1_idx;

  // Cell counter
  logic [IW-1:0] cnt;

  // Previous-column minima
  logic [COST_W-1:0] pf_val, ps_val;
  logic [NW-1:0]     pf_id,  ps_id;

  // Running minima of the current column
  logic [COST_W-1:0] rf_val, rs_val, rf_val_next, rs_val_next;
  logic [NW-1:0]     rf_id,  rs_id,  rf_id_next,  rs_id_next;

  // Running column best
  logic [COST_W-1:0] best_cost, best_cost_next;
  logic [IW-1:0]     best_idx,  best_idx_next;

  // Memory ports and forwarding
  prior_entry_t  rd_data;
  prior_entry_t  wr_data;
  prior_entry_t  prev_entry;
  logic          lw_valid;
  logic [IW-1:0] lw_addr;
  prior_entry_t  lw_data;

  // Cell datapath
  logic [NW-1:0]     idx_id;
  logic [COST_W-1:0] hv;
  logic [NW-1:0]     hid;
  logic [COST_W-1:0] sw_cand, stay_cand, prev_cost, cell_cost;
  logic [NW-1:0]     prev_id, bp_id;

  // Output word
  logic [COST_W-1:0]    out_cost;
  logic [BP_W-1:0]      out_bp;
  logic [COST_W-1:0]    out_best_cost;
  logic [IDX_OUT_W-1:0] out_best_idx;
  logic                 out_last;

  function automatic logic [BP_W-1:0] bp_code(input logic [NW-1:0] id);
    return (id == NONE_ID) ? BP_NONE : BP_W'(id);
  endfunction

  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  vmpc_prior_ram #(
    .DEPTH (MAX_PATHS)
  ) u_prior_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  // Capture the accepted word with its path index; advance the counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (s_tlast || cnt == LAST_IDX) begin
          cnt <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first <= s_tuser[0];
      s1_en    <= s_tuser[1];
      s1_emis  <= s_tdata[15:0];
      s1_sw    <= s_tdata[47:16];
      s1_stay  <= s_tdata[79:48];
      s1_last  <= s_tlast;
      s1_idx   <= cnt;
    end
  end

  // Cell update: pick the cheaper predecessor, add emission, fold into minima.
  always_comb begin
    // Take the last written entry when the memory read missed it.
    prev_entry = (lw_valid && lw_addr == s1_idx) ? lw_data : rd_data;
    idx_id     = NW'(s1_idx);

    // Best other path: skip the minimum when it is this path itself.
    if (idx_id == pf_id) begin
      hv  = ps_val;
      hid = ps_id;
    end else begin
      hv  = pf_val;
      hid = pf_id;
    end
    sw_cand   = sat_add(hv, s1_sw);
    stay_cand = sat_add(prev_entry.cost, s1_stay);

    prev_cost = '0;
    prev_id   = NONE_ID;
    if (!s1_first) begin
      prev_cost = sw_cand;
      prev_id   = hid;
      if (prev_entry.enabled && stay_cand < sw_cand) begin
        prev_cost = stay_cand;
        prev_id   = idx_id;
      end
    end

    if (s1_en) begin
      cell_cost = sat_add(prev_cost, COST_W'(s1_emis));
      bp_id     = prev_id;
    end else begin
      cell_cost = COST_MAX;
      bp_id     = NONE_ID;
    end

    rf_val_next = rf_val;
    rf_id_next  = rf_id;
    rs_val_next = rs_val;
    rs_id_next  = rs_id;
    if (s1_en) begin
      if (cell_cost < rf_val) begin
        rs_val_next = rf_val;
        rs_id_next  = rf_id;
        rf_val_next = cell_cost;
        rf_id_next  = idx_id;
      end else if (cell_cost < rs_val) begin
        rs_val_next = cell_cost;
        rs_id_next  = idx_id;
      end
    end

    // Column best counts every cell; restart at index zero.
    best_cost_next = best_cost;
    best_idx_next  = best_idx;
    if (s1_idx == '0 || cell_cost < best_cost) begin
      best_cost_next = cell_cost;
      best_idx_next  = s1_idx;
    end

    wr_data.enabled = s1_en;
    wr_data.cost    = cell_cost;
  end

  // Commit state as the cell leaves the compute stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pf_val    <= COST_MAX;
      ps_val    <= COST_MAX;
      pf_id     <= NONE_ID;
      ps_id     <= NONE_ID;
      rf_val    <= COST_MAX;
      rs_val    <= COST_MAX;
      rf_id     <= NONE_ID;
      rs_id     <= NONE_ID;
      best_cost <= '0;
      best_idx  <= '0;
      lw_valid  <= 1'b0;
    end else if (s1_adv) begin
      best_cost <= best_cost_next;
      best_idx  <= best_idx_next;
      lw_valid  <= 1'b1;
      if (s1_last) begin
        // Hand the finished column's minima over and restart the running pair.
        pf_val <= rf_val_next;
        ps_val <= rs_val_next;
        pf_id  <= rf_id_next;
        ps_id  <= rs_id_next;
        rf_val <= COST_MAX;
        rs_val <= COST_MAX;
        rf_id  <= NONE_ID;
        rs_id  <= NONE_ID;
      end else begin
        rf_val <= rf_val_next;
        rs_val <= rs_val_next;
        rf_id  <= rf_id_next;
        rs_id  <= rs_id_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      lw_addr <= s1_idx;
      lw_data <= wr_data;
    end
  end

  // Output stage: hold the word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cost      <= cell_cost;
      out_bp        <= bp_code(bp_id);
      out_best_cost <= best_cost_next;
      out_best_idx  <= IDX_OUT_W'(best_idx_next);
      out_last      <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'd0, out_best_idx, out_best_cost, out_bp, out_cost};

endmodule
